>>> rtl/core/oahs_pkg.sv
// Shared types and constants for the open-addressing hash set.
// No dependencies; compiled first.
package oahs_pkg;

  localparam int KEY_W          = 8;
  localparam int CMD_W          = 2;
  localparam int SLOT_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int NUM_KEYS       = 2 ** KEY_W;
  localparam int TABLE_SIZE_DEF = 16;

  // home slot = (key*HASH_MUL_A + key*HASH_MUL_B) mod table size
  localparam int HASH_MUL_A = 7;
  localparam int HASH_MUL_B = 2;

  // command codes; the spare code behaves as a lookup
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] RES_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] RES_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] RES_ABSENT  = 2'd3;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_USED    = 2'd1,
    ST_DELETED = 2'd2
  } slot_state_t;

  typedef struct packed {
    slot_state_t       state;
    logic [KEY_W-1:0]  key;
  } entry_t;

endpackage

>>> rtl/core/oahs_req_if.sv
// Request channel: valid/ready handshake carrying one command word.
// Depends on oahs_pkg.
interface oahs_req_if;
  logic                       valid;
  logic                       ready;
  logic [oahs_pkg::CMD_W-1:0] cmd;
  logic [oahs_pkg::KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

>>> rtl/core/oahs_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on oahs_pkg.
interface oahs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [oahs_pkg::SLOT_W-1:0]   slot_index;
  logic [oahs_pkg::STATUS_W-1:0] status;

  modport source (output valid, found, slot_index, status, input ready);
  modport sink   (input valid, found, slot_index, status, output ready);
endinterface

>>> rtl/core/oahs_table.sv
// Slot store: synchronous-read memory of {state, key} plus per-slot
// valid flops so reset empties the table at once. Depends on oahs_pkg.
module oahs_table #(
  parameter int TABLE_SIZE = oahs_pkg::TABLE_SIZE_DEF,
  localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_W-1:0]    rd_addr,
  output oahs_pkg::entry_t    rd_entry,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  oahs_pkg::entry_t    wr_entry
);
  import oahs_pkg::*;

  entry_t                mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid;
  entry_t                rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid_q <= valid[rd_addr];
    end
  end

  // never-written slot reads as empty
  always_comb begin
    rd_entry = rd_q;
    if (!rd_valid_q) begin
      rd_entry.state = ST_EMPTY;
    end
  end

endmodule

>>> rtl/core/oahs_probe.sv
// Probe sequencer: hashes the key, walks the table one slot per cycle,
// then writes back and loads the result register. Depends on oahs_pkg,
// oahs_req_if and oahs_rsp_if.
module oahs_probe #(
  parameter int TABLE_SIZE = oahs_pkg::TABLE_SIZE_DEF,
  localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  oahs_req_if.sink            req,
  oahs_rsp_if.source          rsp,
  output logic [IDX_W-1:0]    rd_addr,
  input  oahs_pkg::entry_t    rd_entry,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output oahs_pkg::entry_t    wr_entry
);
  import oahs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_DONE} state_t;

  // home slot table, folded at elaboration
  logic [IDX_W-1:0] home_tab [NUM_KEYS];
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_home
    assign home_tab[k] = IDX_W'((k * HASH_MUL_A + k * HASH_MUL_B) % TABLE_SIZE);
  end

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(TABLE_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t                state;
  logic [CMD_W-1:0]      cmd_q;
  logic [KEY_W-1:0]      key_q;
  logic [IDX_W-1:0]      eval_pos;
  logic [IDX_W-1:0]      nxt_pos;
  logic [IDX_W-1:0]      cnt;
  logic                  have_free;
  logic [IDX_W-1:0]      free_pos;
  logic                  hit;
  logic [IDX_W-1:0]      hit_pos;
  logic                  out_valid;
  logic                  out_found;
  logic [SLOT_W-1:0]     out_slot;
  logic [STATUS_W-1:0]   out_status;

  logic [IDX_W-1:0]      home;
  logic                  is_used, is_empty, match, last, stop;
  logic                  load;
  logic                  res_found;
  logic [SLOT_W-1:0]     res_slot;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_write;
  logic [IDX_W-1:0]      res_addr;
  slot_state_t           res_state;

  assign home      = home_tab[req.key];
  assign req.ready = (state == S_IDLE) && !rst;
  assign rd_addr   = (state == S_IDLE) ? home : nxt_pos;

  // probe evaluation on the word that came back for eval_pos
  assign is_used  = (rd_entry.state == ST_USED);
  assign is_empty = (rd_entry.state == ST_EMPTY);
  assign match    = is_used && (rd_entry.key == key_q);
  assign last     = (cnt == IDX_W'(TABLE_SIZE - 1));
  assign stop     = match || is_empty || last;

  // result and write-back decision
  always_comb begin
    res_found  = 1'b0;
    res_slot   = '0;
    res_status = RES_ABSENT;
    res_write  = 1'b0;
    res_addr   = hit_pos;
    res_state  = ST_DELETED;
    if (hit) begin
      res_found = 1'b1;
      res_slot  = SLOT_W'(hit_pos);
      if (cmd_q == CMD_INSERT) begin
        res_status = RES_PRESENT;
      end else begin
        res_status = RES_DONE;
        res_write  = (cmd_q == CMD_DELETE);
      end
    end else if (cmd_q == CMD_INSERT) begin
      if (have_free) begin
        res_slot   = SLOT_W'(free_pos);
        res_status = RES_DONE;
        res_write  = 1'b1;
        res_addr   = free_pos;
        res_state  = ST_USED;
      end else begin
        res_status = RES_FULL;
      end
    end
  end

  assign load           = (state == S_DONE) && (!out_valid || rsp.ready);
  assign wr_en          = load && res_write;
  assign wr_addr        = res_addr;
  assign wr_entry.state = res_state;
  assign wr_entry.key   = key_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q     <= req.cmd;
            key_q     <= req.key;
            eval_pos  <= home;
            nxt_pos   <= wrap_inc(home);
            cnt       <= '0;
            have_free <= 1'b0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (stop) begin
            hit     <= match;
            hit_pos <= eval_pos;
            state   <= S_DONE;
          end
          if (!is_used && !have_free) begin
            have_free <= 1'b1;
            free_pos  <= eval_pos;
          end
          eval_pos <= nxt_pos;
          nxt_pos  <= wrap_inc(nxt_pos);
          cnt      <= cnt + 1'b1;
        end
        S_DONE: begin
          if (load) begin
            out_found  <= res_found;
            out_slot   <= res_slot;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.slot_index = out_slot;
  assign rsp.status     = out_status;

endmodule

>>> rtl/core/open_addressing_hash_set_top.sv
// Top level of the open-addressing hash set (linear probing, byte keys).
// Depends on oahs_pkg, oahs_req_if, oahs_rsp_if, oahs_table, oahs_probe.
//
//   channel | dir | fields                        | one word is
//   --------+-----+-------------------------------+--------------------------
//   req     | in  | cmd[1:0], key[7:0]            | insert / delete / lookup
//   rsp     | out | found, slot_index[3:0], status | outcome of one request
//
// Probing: a request is taken while idle, probes P slots, P from 1 to
//   TABLE_SIZE, then loads its result word. The single read port of the
//   slot memory sets the pace: one slot is examined per cycle.
// A single lap finds the key and remembers the first free slot, so insert
//   never walks the table twice.
// Reset: synchronous, clears the per-slot valid flops at once, so the
//   table is empty immediately; no clearing pass.
// Stalls: req is taken only while the sequencer is idle; a finished word
//   waits in the rsp register, and the next request may already be probing.

module open_addressing_hash_set_top #(
  parameter int TABLE_SIZE = oahs_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  oahs_req_if.sink    req,
  oahs_rsp_if.source  rsp
);
  import oahs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);

  // memory read / write-back between sequencer and slot store
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;

  oahs_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  oahs_probe #(.TABLE_SIZE(TABLE_SIZE)) u_probe (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // once a request is accepted, the sequencer is busy and drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while sequencer busy");

  // table is modified only together with loading a result word
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> rsp.valid)
    else $error("table write without a result word");

  // misses and full table report no slot
  a_miss_no_slot: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == RES_FULL || rsp.status == RES_ABSENT)
      |-> !rsp.found && rsp.slot_index == '0)
    else $error("miss word carries a slot");

  // already-present only when the key was found
  a_present_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == RES_PRESENT |-> rsp.found)
    else $error("already-present without found");

endmodule
